FILE: rtl/vma_pkg.sv
// Shared codes, constants and datapath functions for the Vole machine ALU.
`default_nettype none
package vma_pkg;

	localparam int VMA_REG_COUNT = 16;

	localparam logic [2:0] OP_IADD  = 3'd0;
	localparam logic [2:0] OP_FADD  = 3'd1;
	localparam logic [2:0] OP_OR    = 3'd2;
	localparam logic [2:0] OP_AND   = 3'd3;
	localparam logic [2:0] OP_XOR   = 3'd4;
	localparam logic [2:0] OP_ROTR  = 3'd5;
	localparam logic [2:0] OP_WRITE = 3'd6;
	localparam logic [2:0] OP_NONE  = 3'd7;

	localparam logic [2:0] BIAS_RESET = 3'd4;

	localparam logic [7:0] SIGN_MASK = 8'h80;
	localparam logic [7:0] MAG_SAT   = 8'h7F;

	function automatic logic [7:0] rotr8(input logic [7:0] x, input logic [2:0] k);
		logic [15:0] dbl;
		begin
			dbl = {x, x} >> k;
			return dbl[7:0];
		end
	endfunction

	function automatic logic [7:0] fp_add(input logic [7:0] a, input logic [7:0] b);
		logic [10:0] ma;
		logic [10:0] mb;
		logic [11:0] mag;
		logic        neg;
		logic [2:0]  e;
		logic [11:0] frac;
		begin
			ma = 11'(a[3:0]) << a[6:4];
			mb = 11'(b[3:0]) << b[6:4];
			if (a[7] == b[7]) begin
				mag = 12'(ma) + 12'(mb);
				neg = a[7];
			end else if (ma >= mb) begin
				mag = 12'(ma - mb);
				neg = a[7];
			end else begin
				mag = 12'(mb - ma);
				neg = b[7];
			end
			e = 3'd0;
			for (int i = 4; i < 11; i++) begin
				if (mag[i])
					e = 3'(i - 3);
			end
			frac = mag >> e;
			if (mag == 12'd0)
				return 8'h00;
			else if (mag[11])
				return (neg ? SIGN_MASK : 8'h00) | MAG_SAT;
			else
				return {neg, e, frac[3:0]};
		end
	endfunction

endpackage
`default_nettype wire

FILE: rtl/vole_machine_alu.sv
// Vole machine ALU: register file in a synchronous memory with a compute and write-back stage.
// Result strobe: an accepted start is registered into the s1 stage, then into done.
// Only one item is in flight at a time; the register file memory is read in the
// accept cycle and written back in the following cycle, and busy holds off the
// next item for that write-back.
// Reset clears the register file (per-entry valid bits) and sets the bias to 4.
// The receiver cannot stall: done is a single-cycle strobe.
`default_nettype none
module vole_machine_alu import vma_pkg::*; #(
	parameter int REG_COUNT = VMA_REG_COUNT
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [2:0] cfg_wdata,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [2:0] req_type,
	input  wire logic [3:0] dest_reg,
	input  wire logic [3:0] src_a,
	input  wire logic [3:0] src_b,
	input  wire logic [3:0] rotate_amount,
	input  wire logic [7:0] write_value,
	output logic            done,
	output logic [3:0]      result_index,
	output logic [7:0]      result_value
);

	localparam int AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
	localparam logic [8:0] RC = 9'(REG_COUNT);

	logic [7:0]           rf_mem [REG_COUNT];
	logic [REG_COUNT-1:0] valid_q;
	logic [2:0]           exponent_bias_q;

	logic       vld_s1;
	logic [2:0] req_s1;
	logic [3:0] dst_s1;
	logic [2:0] amt_s1;
	logic [7:0] wval_s1;
	logic       a_ok_s1;
	logic       b_ok_s1;
	logic       dst_ok_s1;
	logic [7:0] a_dat_s1;
	logic [7:0] b_dat_s1;

	logic          done_q;
	logic [3:0]    result_index_q;
	logic [7:0]    result_value_q;

	logic          acc;
	logic [3:0]    ra_idx;
	logic [AW-1:0] ra;
	logic [AW-1:0] rb;
	logic [AW-1:0] wa;
	logic          ra_in;
	logic          rb_in;
	logic          dst_in;
	logic [7:0]    op_a;
	logic [7:0]    op_b;
	logic [7:0]    res;
	logic          wr_en;

	assign acc    = start && !busy;
	assign busy   = vld_s1;
	assign ra     = AW'(ra_idx);
	assign rb     = AW'(src_b);
	assign wa     = AW'(dst_s1);
	assign ra_in  = {5'd0, ra_idx} < RC;
	assign rb_in  = {5'd0, src_b} < RC;
	assign dst_in = {5'd0, dest_reg} < RC;
	assign op_a   = a_ok_s1 ? a_dat_s1 : 8'h00;
	assign op_b   = b_ok_s1 ? b_dat_s1 : 8'h00;
	assign wr_en  = vld_s1 && dst_ok_s1 && (req_s1 != OP_NONE);

	assign done         = done_q;
	assign result_index = result_index_q;
	assign result_value = result_value_q;

	always_comb begin
		if (req_type inside {OP_ROTR, OP_NONE})
			ra_idx = dest_reg;
		else
			ra_idx = src_a;
	end

	always_comb begin
		case (req_s1)
			OP_IADD:  res = op_a + op_b;
			OP_FADD:  res = fp_add(op_a, op_b);
			OP_OR:    res = op_a | op_b;
			OP_AND:   res = op_a & op_b;
			OP_XOR:   res = op_a ^ op_b;
			OP_ROTR:  res = rotr8(op_a, amt_s1);
			OP_WRITE: res = wval_s1;
			default:  res = op_a;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			rf_mem[wa] <= res;
		if (acc) begin
			a_dat_s1 <= rf_mem[ra];
			b_dat_s1 <= rf_mem[rb];
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			req_s1  <= req_type;
			dst_s1  <= dest_reg;
			amt_s1  <= rotate_amount[2:0];
			wval_s1 <= write_value;
		end
		if (vld_s1) begin
			result_index_q <= dst_s1;
			result_value_q <= dst_ok_s1 ? res : 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1          <= 1'b0;
			done_q          <= 1'b0;
			valid_q         <= '0;
			exponent_bias_q <= BIAS_RESET;
			a_ok_s1         <= 1'b0;
			b_ok_s1         <= 1'b0;
			dst_ok_s1       <= 1'b0;
		end else begin
			vld_s1 <= acc;
			done_q <= vld_s1;
			if (cfg_we)
				exponent_bias_q <= cfg_wdata;
			if (wr_en)
				valid_q[wa] <= 1'b1;
			if (acc) begin
				a_ok_s1   <= ra_in && valid_q[ra];
				b_ok_s1   <= rb_in && valid_q[rb];
				dst_ok_s1 <= dst_in;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/vma_checker.sv
// Port-level checker for the Vole machine ALU and its bind to the top level.
`default_nettype none
module vma_checker import vma_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic [3:0] dest_reg,
	input wire logic       done,
	input wire logic [3:0] result_index
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after an accepted item");

	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done && !busy)
		else $error("no result strobe after the busy cycle");

	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without an item in flight");

	a_index: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##2 (result_index == $past(dest_reg, 2)))
		else $error("result index differs from the item's destination");

endmodule

bind vole_machine_alu vma_checker u_vma_checker (.*);
`default_nettype wire
